// ===== sv/id3t_pkg.sv =====
// Shared types and constants for the ID3 text to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none
package id3t_pkg;

   localparam logic [7:0] ENC_LATIN1   = 8'd0;
   localparam logic [7:0] ENC_UTF16BOM = 8'd1;
   localparam logic [7:0] ENC_UTF16BE  = 8'd2;
   localparam logic [7:0] ENC_UTF8     = 8'd3;

   localparam logic REG_ENCODING = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   localparam logic [9:0] CAPACITY_RESET = 10'd192;

   localparam logic [7:0]  BOM_FF       = 8'hFF;
   localparam logic [7:0]  BOM_FE       = 8'hFE;
   localparam logic [5:0]  HIGH_SUR_TAG = 6'b110110;
   localparam logic [5:0]  LOW_SUR_TAG  = 6'b110111;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_first;
      logic       text_last;
   } id3t_req_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       run_last;
   } id3t_rsp_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } id3t_burst_type;

   function automatic id3t_burst_type encode_cp(input logic [20:0] cp);
      id3t_burst_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.count    = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.count    = 3'd2;
      end else if (cp < 21'h10000) begin
         if (cp < 21'hD800 || cp > 21'hDFFF) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.count    = 3'd3;
         end
      end else if (cp <= 21'h10FFFF) begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.count    = 3'd4;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/id3t_front.sv =====
// Front end: accepts raw bytes, tracks text state and decodes to UTF-8 bursts.
`timescale 1ns / 1ps
`default_nettype none
module id3t_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire id3t_pkg::id3t_req_type  req_payload,
   input  wire logic [7:0]              text_encoding,
   input  wire logic [9:0]              output_capacity,
   output logic                         q_push,
   output id3t_pkg::id3t_burst_type     q_data,
   input  wire logic                    q_full
);
   import id3t_pkg::*;

   logic       half_ff, half_in;
   logic [7:0] held_ff, held_in;
   logic [9:0] pend_ff, pend_in;
   logic       pvalid_ff, pvalid_in;
   logic       be_ff, be_in;
   logic       funit_ff, funit_in;
   logic       stop_ff, stop_in;
   logic [9:0] count_ff, count_in;

   logic           accept;
   logic           e_half, e_pvalid, e_be, e_funit, e_stop;
   logic [7:0]     e_held;
   logic [9:0]     e_pend, e_count;
   logic           cap_hit, bom, use_be;
   logic [7:0]     byte_v;
   logic [15:0]    unit;
   id3t_burst_type burst;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign q_push   = accept && (burst.count != 3'd0);
   assign q_data   = burst;
   assign byte_v   = req_payload.in_byte;

   always_comb begin
      if (req_payload.text_first) begin
         e_half = 1'b0; e_held = '0; e_pend = '0; e_pvalid = 1'b0;
         e_be = 1'b0; e_funit = 1'b1; e_stop = 1'b0; e_count = '0;
      end else begin
         e_half = half_ff; e_held = held_ff; e_pend = pend_ff; e_pvalid = pvalid_ff;
         e_be = be_ff; e_funit = funit_ff; e_stop = stop_ff; e_count = count_ff;
      end
   end

   always_comb begin
      half_in   = e_half;
      held_in   = e_held;
      pend_in   = e_pend;
      pvalid_in = e_pvalid;
      be_in     = e_be;
      funit_in  = e_funit;
      stop_in   = e_stop;
      burst     = '0;
      bom       = 1'b0;
      use_be    = 1'b0;
      unit      = '0;
      cap_hit   = ({1'b0, e_count} + 11'd4) > {1'b0, output_capacity};
      if (!e_stop) begin
         if (text_encoding == ENC_LATIN1) begin
            if (cap_hit || byte_v == 8'd0) stop_in = 1'b1;
            else burst = encode_cp({13'd0, byte_v});
         end else if (text_encoding == ENC_UTF8) begin
            if (byte_v == 8'd0 || e_count >= output_capacity) begin
               stop_in = 1'b1;
            end else begin
               burst.bytes[0] = byte_v;
               burst.count    = 3'd1;
            end
         end else if (text_encoding == ENC_UTF16BOM || text_encoding == ENC_UTF16BE) begin
            if (!e_half) begin
               held_in = byte_v;
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               if (text_encoding == ENC_UTF16BOM && e_funit) begin
                  if (e_held == BOM_FF && byte_v == BOM_FE) begin
                     be_in = 1'b0;
                     bom   = 1'b1;
                  end else if (e_held == BOM_FE && byte_v == BOM_FF) begin
                     be_in = 1'b1;
                     bom   = 1'b1;
                  end else begin
                     be_in = 1'b0;
                  end
               end
               funit_in = 1'b0;
               if (!bom) begin
                  use_be = (text_encoding == ENC_UTF16BE) ? 1'b1 : be_in;
                  unit   = use_be ? {e_held, byte_v} : {byte_v, e_held};
                  if (e_pvalid) begin
                     pvalid_in = 1'b0;
                     if (unit[15:10] != LOW_SUR_TAG) stop_in = 1'b1;
                     else burst = encode_cp(SUPP_BASE + {1'b0, e_pend, unit[9:0]});
                  end else if (cap_hit || unit == 16'd0) begin
                     stop_in = 1'b1;
                  end else if (unit[15:10] == HIGH_SUR_TAG) begin
                     pend_in   = unit[9:0];
                     pvalid_in = 1'b1;
                  end else begin
                     burst = encode_cp({5'd0, unit});
                  end
               end
            end
         end
      end
      count_in = e_count + {7'd0, burst.count};
      if (req_payload.text_last) stop_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff   <= 1'b0;
         held_ff   <= '0;
         pend_ff   <= '0;
         pvalid_ff <= 1'b0;
         be_ff     <= 1'b0;
         funit_ff  <= 1'b1;
         stop_ff   <= 1'b0;
         count_ff  <= '0;
      end else if (accept) begin
         half_ff   <= half_in;
         held_ff   <= held_in;
         pend_ff   <= pend_in;
         pvalid_ff <= pvalid_in;
         be_ff     <= be_in;
         funit_ff  <= funit_in;
         stop_ff   <= stop_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/id3t_queue.sv =====
// Short queue of decoded bursts between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module id3t_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire id3t_pkg::id3t_burst_type  data_in,
   output logic                           full,
   input  wire logic                      pop,
   output id3t_pkg::id3t_burst_type       data_out,
   output logic                           empty
);
   import id3t_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   id3t_burst_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/id3t_back.sv =====
// Back end: serializes queued bursts onto the result channel one byte at a time.
`timescale 1ns / 1ps
`default_nettype none
module id3t_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_empty,
   input  wire id3t_pkg::id3t_burst_type  q_data,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output id3t_pkg::id3t_rsp_type         rsp_payload
);
   import id3t_pkg::*;

   logic           busy_ff, busy_in;
   id3t_burst_type cur_ff, cur_in;
   logic [1:0]     idx_ff, idx_in;
   logic           last_byte, done;

   assign last_byte = ({1'b0, idx_ff} == (cur_ff.count - 3'd1));
   assign done      = busy_ff && rsp_pop && last_byte;
   assign q_pop     = !q_empty && (!busy_ff || done);
   assign rsp_empty = !busy_ff;
   assign rsp_payload.utf8_byte = cur_ff.bytes[idx_ff];
   assign rsp_payload.run_last  = last_byte;

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      if (q_pop) begin
         cur_in  = q_data;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_pop) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/id3_text_to_utf8_transcoder_unit.sv =====
// Top level of the ID3 text to UTF-8 transcoder with its register port.
//
//   channel   ports                       moves per transfer
//   req       req_push / req_full         one raw text byte with first/last flags
//   rsp       rsp_pop / rsp_empty         one UTF-8 byte with run_last
//   csr       csr_psel/penable/pwrite     encoding (0x0) and capacity (0x4)
//
// Each input byte is decoded in the cycle it is taken and yields 0 to 4 bytes.
// Input is taken every cycle while the burst queue has room.
// Results leave one per cycle while rsp_pop is high and a queued burst is ready.
// A byte's first result is registered in the burst queue, then in the back end.
// Synchronous reset clears the queue and text state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module id3_text_to_utf8_transcoder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire id3t_pkg::id3t_req_type  req_payload,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output id3t_pkg::id3t_rsp_type       rsp_payload,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [2:0]              csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import id3t_pkg::*;

   logic [7:0]     enc_ff;
   logic [9:0]     cap_ff;
   logic           csr_write;
   logic           q_push, q_full, q_pop, q_empty;
   id3t_burst_type q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? {22'd0, cap_ff} : {24'd0, enc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff <= ENC_LATIN1;
         cap_ff <= CAPACITY_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_ENCODING) enc_ff <= csr_pwdata[7:0];
         else cap_ff <= csr_pwdata[9:0];
      end
   end

   id3t_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_payload     (req_payload),
      .text_encoding   (enc_ff),
      .output_capacity (cap_ff),
      .q_push          (q_push),
      .q_data          (q_wdata),
      .q_full          (q_full)
   );

   id3t_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .data_out (q_rdata),
      .empty    (q_empty)
   );

   id3t_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== sv/id3t_checker.sv =====
// Port-level checks for the transcoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module id3t_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_push,
   input wire logic                    req_full,
   input wire logic                    rsp_empty,
   input wire logic                    rsp_pop,
   input wire id3t_pkg::id3t_rsp_type  rsp_payload,
   input wire logic                    csr_pready
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_room_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input side full after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_payload)))
      else $error("waiting result changed or vanished");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      (req_push || !req_push) |-> csr_pready)
      else $error("register port not ready");

endmodule

bind id3_text_to_utf8_transcoder_unit id3t_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_push    (req_push),
   .req_full    (req_full),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_payload (rsp_payload),
   .csr_pready  (csr_pready)
);
`default_nettype wire
